[src/pgv_pkg.sv]
// ----------------------------------------------------------------------------
// pgv_pkg: shared types and constants
// Beat structures, classified job record, status and register codes for the
// pairwise gravity velocity update block.
// ----------------------------------------------------------------------------
package pgv_pkg;

    // Pair status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SAME  = 3'd1;
    localparam logic [2:0] ST_ZMASS = 3'd2;
    localparam logic [2:0] ST_COINC = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_GRAV = 2'd0;
    localparam logic [1:0] REG_STEP = 2'd1;

    localparam logic [31:0] GRAV_RESET = 32'h0100_0000;
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_a_z;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] pos_b_z;
        logic [31:0]        mass_a;
        logic [31:0]        mass_b;
        logic               same_body;
    } pgv_in_t;

    typedef struct packed {
        logic signed [31:0] dv_a_x;
        logic signed [31:0] dv_a_y;
        logic signed [31:0] dv_a_z;
        logic signed [31:0] dv_b_x;
        logic signed [31:0] dv_b_y;
        logic signed [31:0] dv_b_z;
        logic [2:0]         pair_status;
    } pgv_out_t;

    // Classified pair handed from the front to the back
    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        neg;
        logic [2:0][32:0]  mag;
        logic [31:0]       mass_a;
        logic [31:0]       mass_b;
    } pgv_job_t;

endpackage

[src/pgv_front.sv]
// ----------------------------------------------------------------------------
// pgv_front: input stage
// Accepts one pair per cycle while full is low, forms the separation vector and
// classifies the pair (same body, zero mass, coincident) into a job record.
// ----------------------------------------------------------------------------
module pgv_front
    import pgv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  pgv_in_t  in_data,
    output pgv_job_t job,
    output logic     job_valid,
    input  logic     job_ready
);

    logic         valid_reg;
    pgv_job_t     job_reg;
    pgv_job_t     job_next;
    logic         accept;
    logic [2:0][32:0] diff;
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;

    assign full   = valid_reg && !job_ready;
    assign accept = push && !full;

    assign pa[0] = in_data.pos_a_x;
    assign pa[1] = in_data.pos_a_y;
    assign pa[2] = in_data.pos_a_z;
    assign pb[0] = in_data.pos_b_x;
    assign pb[1] = in_data.pos_b_y;
    assign pb[2] = in_data.pos_b_z;

    // Separation, sign and magnitude per axis, and the pair classification
    always_comb
    begin
        job_next        = '0;
        job_next.mass_a = in_data.mass_a;
        job_next.mass_b = in_data.mass_b;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
            job_next.neg[i] = diff[i][32];
            job_next.mag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
        end
        if (in_data.same_body)
            job_next.status = ST_SAME;
        else if (in_data.mass_a == 32'd0 || in_data.mass_b == 32'd0)
            job_next.status = ST_ZMASS;
        else if (diff[0] == 33'd0 && diff[1] == 33'd0 && diff[2] == 33'd0)
            job_next.status = ST_COINC;
        else
            job_next.status = ST_OK;
    end

    // Hold the classified beat until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job       = job_reg;
    assign job_valid = valid_reg;

endmodule

[src/pgv_fifo.sv]
// ----------------------------------------------------------------------------
// pgv_fifo: two-entry job queue
// Decouples the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
module pgv_fifo
    import pgv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  pgv_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_pop,
    output pgv_job_t rd_data
);

    pgv_job_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[src/pgv_core.sv]
// ----------------------------------------------------------------------------
// pgv_core: arithmetic back end
// Sequencer around one shift-add multiplier, a digit-by-digit square root
// and a restoring divider; writes one result beat per job.
// ----------------------------------------------------------------------------
module pgv_core
    import pgv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pgv_job_t    job,
    input  logic        job_valid,
    output logic        job_pop,
    input  logic [31:0] grav_const,
    input  logic [31:0] time_step,
    output pgv_out_t    out_data,
    output logic        empty,
    input  logic        pop
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_DEN, S_GDT, S_KA, S_KB, S_NUM, S_DIV, S_FIN
    } state_t;

    state_t           state_reg;
    pgv_job_t         job_reg;
    logic [129:0]     acc_reg;
    logic [129:0]     mcand_reg;
    logic [33:0]      mplier_reg;
    logic [5:0]       cnt_reg;
    logic [1:0]       idx_reg;
    logic [65:0]      s_reg;
    logic [67:0]      sq_src_reg;
    logic [35:0]      rem_reg;
    logic [33:0]      root_reg;
    logic [106:0]     den_reg;
    logic [63:0]      gdt_reg;
    logic [95:0]      ka_reg;
    logic [95:0]      kb_reg;
    logic [2:0]       comp_reg;
    logic [128:0]     drem_reg;
    logic [138:0]     dsh_reg;
    logic [31:0]      q_reg;
    logic             ovr_reg;
    logic             sat_reg;
    logic [5:0][31:0] dv_reg;
    pgv_out_t         out_reg;
    logic             out_valid_reg;

    logic [129:0] acc_sum;
    logic         last;
    logic [35:0]  rem_t;
    logic [35:0]  trial;
    logic         take_r;
    logic [33:0]  root_step;
    logic [35:0]  rem_step;
    logic [138:0] drem_ext;
    logic         take_d;
    logic [138:0] drem_sub;
    logic [31:0]  q_step;
    logic         num_over;
    logic [1:0]   cidx;
    logic         neg_c;
    logic [31:0]  limit;
    logic         big;
    logic [31:0]  mag_c;
    logic [2:0]   comp_inc;
    logic [1:0]   nidx;
    logic [95:0]  k_n;
    logic         out_free;

    // Multiplier step: add the shifted multiplicand under the low multiplier bit
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : 130'd0);
    assign last    = cnt_reg == 6'd1;

    // Square root step: two radicand bits per cycle
    assign rem_t     = {rem_reg[33:0], sq_src_reg[67:66]};
    assign trial     = {root_reg, 2'b01};
    assign take_r    = rem_t >= trial;
    assign root_step = {root_reg[32:0], take_r};
    assign rem_step  = take_r ? (rem_t - trial) : rem_t;

    // Divider step: one quotient bit per cycle
    assign drem_ext = {10'd0, drem_reg};
    assign take_d   = drem_ext >= dsh_reg;
    assign drem_sub = take_d ? (drem_ext - dsh_reg) : drem_ext;
    assign q_step   = {q_reg[30:0], take_d};
    assign num_over = {10'd0, acc_sum[128:0]} >= {den_reg, 32'd0};

    // Component finish: sign, clamp
    assign cidx  = (comp_reg < 3'd3) ? comp_reg[1:0] : 2'(comp_reg - 3'd3);
    assign neg_c = (comp_reg < 3'd3) ?
                   (!job_reg.neg[cidx] && job_reg.mag[cidx] != 33'd0) : job_reg.neg[cidx];
    assign limit = neg_c ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign big   = ovr_reg || q_step > limit;
    assign mag_c = big ? limit : q_step;

    // Next component operands
    assign comp_inc = comp_reg + 3'd1;
    assign nidx     = (comp_inc < 3'd3) ? comp_inc[1:0] : 2'(comp_inc - 3'd3);
    assign k_n      = (comp_inc < 3'd3) ? ka_reg : kb_reg;

    assign out_free = !out_valid_reg || pop;
    assign job_pop  = (state_reg == S_IDLE) && job_valid;
    assign out_data = out_reg;
    assign empty    = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise the result beat when finished, drop it once taken
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg    <= job;
                        sat_reg    <= 1'b0;
                        dv_reg     <= '0;
                        acc_reg    <= '0;
                        mcand_reg  <= {97'd0, job.mag[0]};
                        mplier_reg <= {1'b0, job.mag[0]};
                        cnt_reg    <= 6'd34;
                        idx_reg    <= 2'd0;
                        state_reg  <= (job.status != ST_OK) ? S_FIN : S_SQ;
                    end
                end
                S_SQ:
                begin
                    acc_reg <= acc_sum;
                    if (last)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            s_reg      <= acc_sum[65:0];
                            sq_src_reg <= {2'b00, acc_sum[65:0]};
                            rem_reg    <= '0;
                            root_reg   <= '0;
                            cnt_reg    <= 6'd34;
                            state_reg  <= S_SQRT;
                        end
                        else
                        begin
                            idx_reg    <= idx_reg + 2'd1;
                            mcand_reg  <= {97'd0, job_reg.mag[idx_reg + 2'd1]};
                            mplier_reg <= {1'b0, job_reg.mag[idx_reg + 2'd1]};
                            cnt_reg    <= 6'd34;
                        end
                    end
                    else
                    begin
                        mcand_reg  <= {mcand_reg[128:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[33:1]};
                        cnt_reg    <= cnt_reg - 6'd1;
                    end
                end
                S_SQRT:
                begin
                    rem_reg    <= rem_step;
                    root_reg   <= root_step;
                    sq_src_reg <= {sq_src_reg[65:0], 2'b00};
                    if (last)
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= {64'd0, s_reg};
                        mplier_reg <= root_step;
                        cnt_reg    <= 6'd34;
                        state_reg  <= S_DEN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_DEN, S_GDT, S_KA, S_KB, S_NUM:
                begin
                    if (last)
                    begin
                        acc_reg <= '0;
                        case (state_reg)
                            S_DEN:
                            begin
                                den_reg    <= {acc_sum[98:0], 8'd0};
                                mcand_reg  <= {98'd0, grav_const};
                                mplier_reg <= {2'b00, time_step};
                                cnt_reg    <= 6'd34;
                                state_reg  <= S_GDT;
                            end
                            S_GDT:
                            begin
                                gdt_reg    <= acc_sum[63:0];
                                mcand_reg  <= {66'd0, acc_sum[63:0]};
                                mplier_reg <= {2'b00, job_reg.mass_b};
                                cnt_reg    <= 6'd34;
                                state_reg  <= S_KA;
                            end
                            S_KA:
                            begin
                                ka_reg     <= acc_sum[95:0];
                                mcand_reg  <= {66'd0, gdt_reg};
                                mplier_reg <= {2'b00, job_reg.mass_a};
                                cnt_reg    <= 6'd34;
                                state_reg  <= S_KB;
                            end
                            S_KB:
                            begin
                                kb_reg     <= acc_sum[95:0];
                                comp_reg   <= 3'd0;
                                mcand_reg  <= {34'd0, ka_reg};
                                mplier_reg <= {1'b0, job_reg.mag[0]};
                                cnt_reg    <= 6'd34;
                                state_reg  <= S_NUM;
                            end
                            default:
                            begin
                                drem_reg  <= acc_sum[128:0];
                                dsh_reg   <= {1'b0, den_reg, 31'd0};
                                ovr_reg   <= num_over;
                                q_reg     <= '0;
                                cnt_reg   <= 6'd32;
                                state_reg <= S_DIV;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg    <= acc_sum;
                        mcand_reg  <= {mcand_reg[128:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[33:1]};
                        cnt_reg    <= cnt_reg - 6'd1;
                    end
                end
                S_DIV:
                begin
                    drem_reg <= drem_sub[128:0];
                    dsh_reg  <= {1'b0, dsh_reg[138:1]};
                    q_reg    <= q_step;
                    if (last)
                    begin
                        dv_reg[comp_reg] <= neg_c ? (32'd0 - mag_c) : mag_c;
                        if (big)
                            sat_reg <= 1'b1;
                        if (comp_reg == 3'd5)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            comp_reg   <= comp_inc;
                            acc_reg    <= '0;
                            mcand_reg  <= {34'd0, k_n};
                            mplier_reg <= {1'b0, job_reg.mag[nidx]};
                            cnt_reg    <= 6'd34;
                            state_reg  <= S_NUM;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg.dv_a_x <= dv_reg[0];
                        out_reg.dv_a_y <= dv_reg[1];
                        out_reg.dv_a_z <= dv_reg[2];
                        out_reg.dv_b_x <= dv_reg[3];
                        out_reg.dv_b_y <= dv_reg[4];
                        out_reg.dv_b_z <= dv_reg[5];
                        out_reg.pair_status <= (job_reg.status != ST_OK) ? job_reg.status :
                                               (sat_reg ? ST_SAT : ST_OK);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/pairwise_gravity_velocity_update.sv]
// ----------------------------------------------------------------------------
// pairwise_gravity_velocity_update: Newtonian pair velocity update
// Usage:
//   Push one body pair on in_data when full is low; the pair is taken at the
//   clock edge where push is high and full is low. Results come out in order
//   as a queue: while empty is low, out_data holds the oldest result and pop
//   takes it. Config writes (cfg_index 0 = grav_const, 1 = time_step) are
//   taken on cfg_valid, cfg_ready is always high; write only while idle.
// Timing:
//   The front classifies a pair into a register and parks it in a 2-entry queue.
//   The back end works an applied pair through its one shared shift-add
//   multiplier (13 products), the 34-step square root and six 32-step
//   divisions; a rejected pair (same body, zero mass, coincident) goes
//   straight to the result. The back end takes a new pair only once it is
//   idle again, so it works on one pair at a time.
//   The front keeps taking pairs while a result waits to be popped, until the
//   queue fills; a stalled receiver then raises full.
// Reset:
//   rst_n clears all queues and restores grav_const = 1.0 and time_step = 1.0.
// ----------------------------------------------------------------------------
module pairwise_gravity_velocity_update
    import pgv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  pgv_in_t     in_data,
    output logic        empty,
    input  logic        pop,
    output pgv_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] grav_reg;
    logic [31:0] step_reg;
    pgv_job_t    front_job;
    logic        front_valid;
    logic        q_ready;
    pgv_job_t    q_job;
    logic        q_valid;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    // Hold configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= GRAV_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRAV: grav_reg <= cfg_data;
                REG_STEP: step_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    pgv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (q_ready)
    );

    pgv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (q_ready),
        .wr_data  (front_job),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_job)
    );

    pgv_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (q_job),
        .job_valid  (q_valid),
        .job_pop    (q_pop),
        .grav_const (grav_reg),
        .time_step  (step_reg),
        .out_data   (out_data),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTH
    // Rejected pairs carry no velocity change on the x and z axes
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_data.pair_status == ST_SAME || out_data.pair_status == ST_ZMASS ||
                    out_data.pair_status == ST_COINC)) |->
        (out_data.dv_a_x == 32'd0 && out_data.dv_b_x == 32'd0 &&
         out_data.dv_a_z == 32'd0 && out_data.dv_b_z == 32'd0))
        else $error("rejected pair with nonzero change");

    // The two bodies are never both pushed in the negative direction along x or y
    a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(out_data.dv_a_x[31] && out_data.dv_b_x[31]) &&
                   !(out_data.dv_a_y[31] && out_data.dv_b_y[31]))
        else $error("both bodies accelerate the same way");

    // Status stays within its defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_data.pair_status <= ST_SAT)
        else $error("undefined pair status");
`endif

endmodule
